// ===== rtl/vr_pkg.sv =====
// Shared types and constants for the vector refraction block.
// Used by vr_front, vr_queue, vr_back and the top level; no dependencies.
package vr_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Word handed from the front part to the back part through the queue
  typedef struct packed {
    logic             tir;
    logic             aneg;
    logic [39:0]      amag;
    logic [33:0]      c;
    logic [31:0]      b;
    logic [2:0][31:0] d;
    logic [2:0]       nneg;
    logic [2:0][31:0] nm;
  } qent_t;

endpackage

// ===== rtl/vector_refraction.sv =====
// Top level of the vector refraction block: front pipeline, queue, back pipeline.
// Depends on vr_pkg, vr_front, vr_queue and vr_back.
//
// Refracts a ray direction at a surface by the vector form of Snell's law, in
// signed Q2.30 vectors and unsigned Q4.28 indices, saturating every result;
// on total internal reflection it returns the mirror direction and raises
// out_total_reflect. The block is fully pipelined and takes one ray per cycle
// while in_ready is high. The front pipeline holds the index ratio divider
// (two quotient bits per stage) and the square root (two root bits per stage).
// A four-word queue sits between front and back, so a stalled result side
// stops the front only when the queue is full.
module vector_refraction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_norm_x,
  input  logic [31:0] in_norm_y,
  input  logic [31:0] in_norm_z,
  input  logic [31:0] in_index_from,
  input  logic [31:0] in_index_to,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        out_total_reflect
);

  vr_pkg::qent_t push_data;
  vr_pkg::qent_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  vr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .in_norm_x     (in_norm_x),
    .in_norm_y     (in_norm_y),
    .in_norm_z     (in_norm_z),
    .in_index_from (in_index_from),
    .in_index_to   (in_index_to),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  vr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  vr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_total_reflect (out_total_reflect)
  );

endmodule

// ===== rtl/vr_front.sv =====
// Front part: dot product, index ratio divider, d2 and square root pipeline.
// Depends on vr_pkg (qent_t). Feeds vr_queue.
module vr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_dir_x,
  input  logic [31:0]    in_dir_y,
  input  logic [31:0]    in_dir_z,
  input  logic [31:0]    in_norm_x,
  input  logic [31:0]    in_norm_y,
  input  logic [31:0]    in_norm_z,
  input  logic [31:0]    in_index_from,
  input  logic [31:0]    in_index_to,
  input  logic           q_full,
  output logic           push,
  output vr_pkg::qent_t  push_data
);

  localparam int FR_LAST   = 43;
  localparam int ST_MUL    = 1;
  localparam int ST_DOT    = 2;
  localparam int ST_MAG    = 3;
  localparam int DIV_FIRST = 1;
  localparam int DIV_LAST  = 16;
  localparam int ST_BFIN   = 17;
  localparam int ST_SQR    = 18;
  localparam int ST_M      = 19;
  localparam int ST_PP     = 20;
  localparam int ST_PROD   = 21;
  localparam int ST_D2     = 22;
  localparam int SQ_FIRST  = 23;
  localparam int SQ_LAST   = 42;
  localparam int ST_AMAG   = 43;

  localparam logic [37:0] ONE38 = 38'h0_4000_0000;
  localparam logic [45:0] ONE46 = 46'h0_4000_0000;

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] n;
    logic [31:0]      n1;
    logic [31:0]      n2;
    logic [2:0][63:0] p;
    logic [65:0]      dot;
    logic             zerodot;
    logic [33:0]      c;
    logic [2:0]       nneg;
    logic [2:0][31:0] nm;
    logic             dsat;
    logic [31:0]      drem;
    logic [31:0]      dlo;
    logic [31:0]      dq;
    logic [31:0]      b;
    logic [63:0]      ccl;
    logic [33:0]      cch;
    logic [63:0]      bb;
    logic [63:0]      bcl;
    logic [33:0]      bch;
    logic [37:0]      c2;
    logic [37:0]      b2;
    logic [37:0]      m;
    logic [37:0]      bc;
    logic             mpos;
    logic [63:0]      pll;
    logic [37:0]      plh;
    logic [37:0]      phl;
    logic [11:0]      phh;
    logic [45:0]      prod;
    logic             tir;
    logic [79:0]      rad;
    logic [39:0]      root;
    logic [43:0]      srem;
    logic [39:0]      amag;
    logic             aneg;
  } fr_t;

  // One restoring division step: one quotient bit
  function automatic fr_t div_step(input fr_t s);
    fr_t         r;
    logic [32:0] t;
    r = s;
    t = {s.drem, s.dlo[31]};
    if (t >= {1'b0, s.n2}) begin
      r.drem = 32'(t - {1'b0, s.n2});
      r.dq   = {s.dq[30:0], 1'b1};
    end else begin
      r.drem = t[31:0];
      r.dq   = {s.dq[30:0], 1'b0};
    end
    r.dlo = {s.dlo[30:0], 1'b0};
    return r;
  endfunction

  // One digit-by-digit square root step: one root bit
  function automatic fr_t sqrt_step(input fr_t s);
    fr_t         r;
    logic [43:0] rm;
    logic [43:0] tr;
    r  = s;
    rm = {s.srem[41:0], s.rad[79:78]};
    tr = {2'b00, s.root, 2'b01};
    if (rm >= tr) begin
      r.srem = rm - tr;
      r.root = {s.root[38:0], 1'b1};
    end else begin
      r.srem = rm;
      r.root = {s.root[38:0], 1'b0};
    end
    r.rad = {s.rad[77:0], 2'b00};
    return r;
  endfunction

  function automatic fr_t stage_fn(input fr_t s, input int j);
    fr_t                r;
    logic signed [31:0] ds;
    logic signed [31:0] ns;
    logic signed [63:0] ps;
    logic [65:0]        acc;
    logic [63:0]        mg;
    logic [67:0]        cc;
    logic [3:0]         chh;
    logic [65:0]        bcw;
    logic [75:0]        pr;
    logic [45:0]        d2;
    logic [39:0]        bcx;
    r = s;
    if (j == ST_MUL) begin
      for (int k = 0; k < 3; k++) begin
        ds = s.d[k];
        ns = s.n[k];
        ps = ds * ns;
        r.p[k] = ps;
      end
      // saturate when the ratio reaches 16, so the quotient would reach 2^32 (also covers a zero divisor)
      r.dsat = {4'b0000, s.n1} >= {s.n2, 4'b0000};
      r.drem = {4'b0000, s.n1[31:4]};
      r.dlo  = {s.n1[3:0], 28'd0};
      r.dq   = '0;
    end
    if (j >= DIV_FIRST && j <= DIV_LAST) begin
      r = div_step(div_step(r));
    end
    if (j == ST_DOT) begin
      r.dot = {{2{s.p[0][63]}}, s.p[0]} + {{2{s.p[1][63]}}, s.p[1]}
            + {{2{s.p[2][63]}}, s.p[2]};
    end
    if (j == ST_MAG) begin
      acc       = s.dot[65] ? (~s.dot + 66'd1) : s.dot;
      mg        = acc[63:0];
      r.c       = mg[63:30];
      r.zerodot = (mg == 64'd0);
      for (int k = 0; k < 3; k++) begin
        // flip the normal unless the dot product is negative
        r.nneg[k] = s.dot[65] ? s.n[k][31] : (!s.n[k][31] && (s.n[k] != 32'd0));
        r.nm[k]   = s.n[k][31] ? (~s.n[k] + 32'd1) : s.n[k];
      end
    end
    if (j == ST_BFIN) begin
      r.b   = s.dsat ? '1 : s.dq;
      r.ccl = s.c[31:0] * s.c[31:0];
      r.cch = s.c[31:0] * s.c[33:32];
    end
    if (j == ST_SQR) begin
      chh   = s.c[33:32] * s.c[33:32];
      cc    = {4'b0000, s.ccl} + {1'b0, s.cch, 33'd0} + {chh, 64'd0};
      r.c2  = cc[67:30];
      r.bb  = s.b * s.b;
      r.bcl = s.b * s.c[31:0];
      r.bch = s.b * s.c[33:32];
    end
    if (j == ST_M) begin
      r.b2   = s.bb[63:26];
      r.mpos = s.c2 <= ONE38;
      r.m    = (s.c2 <= ONE38) ? (ONE38 - s.c2) : (s.c2 - ONE38);
      bcw    = {2'b00, s.bcl} + {s.bch, 32'd0};
      r.bc   = bcw[65:28];
    end
    if (j == ST_PP) begin
      r.pll = s.b2[31:0] * s.m[31:0];
      r.plh = s.b2[31:0] * s.m[37:32];
      r.phl = s.b2[37:32] * s.m[31:0];
      r.phh = s.b2[37:32] * s.m[37:32];
    end
    if (j == ST_PROD) begin
      pr = {12'd0, s.pll} + {6'd0, s.plh, 32'd0} + {6'd0, s.phl, 32'd0}
         + {s.phh, 64'd0};
      r.prod = pr[75:30];
    end
    if (j == ST_D2) begin
      r.tir = s.mpos && (s.prod > ONE46);
      if (r.tir) begin
        d2 = '0;
      end else if (s.mpos) begin
        d2 = ONE46 - s.prod;
      end else begin
        d2 = ONE46 + s.prod;
      end
      r.rad  = {4'd0, d2, 30'd0};
      r.root = '0;
      r.srem = '0;
    end
    if (j >= SQ_FIRST && j <= SQ_LAST) begin
      r = sqrt_step(sqrt_step(r));
    end
    if (j == ST_AMAG) begin
      bcx = {2'b00, s.bc};
      if (s.zerodot) begin
        r.amag = s.root;
        r.aneg = 1'b0;
      end else begin
        r.aneg = bcx < s.root;
        r.amag = (bcx < s.root) ? (s.root - bcx) : (bcx - s.root);
      end
    end
    return r;
  endfunction

  fr_t              st_r   [0:FR_LAST];
  fr_t              st_nxt [0:FR_LAST];
  logic [FR_LAST:0] vld_r;
  logic             en;

  // hold the whole pipe only when its last word cannot enter the queue
  assign en       = !(vld_r[FR_LAST] && q_full);
  assign in_ready = en;
  assign push     = vld_r[FR_LAST] && !q_full;

  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].d[0] = in_dir_x;
    st_nxt[0].d[1] = in_dir_y;
    st_nxt[0].d[2] = in_dir_z;
    st_nxt[0].n[0] = in_norm_x;
    st_nxt[0].n[1] = in_norm_y;
    st_nxt[0].n[2] = in_norm_z;
    st_nxt[0].n1   = in_index_from;
    st_nxt[0].n2   = in_index_to;
  end

  for (genvar j = 1; j <= FR_LAST; j++) begin : g_stage
    always_comb st_nxt[j] = stage_fn(st_r[j-1], j);
  end

  for (genvar j = 0; j <= FR_LAST; j++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) st_r[j] <= st_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FR_LAST-1:0], in_valid};
    end
  end

  always_comb begin
    push_data.tir  = st_r[FR_LAST].tir;
    push_data.aneg = st_r[FR_LAST].aneg;
    push_data.amag = st_r[FR_LAST].amag;
    push_data.c    = st_r[FR_LAST].c;
    push_data.b    = st_r[FR_LAST].b;
    push_data.d    = st_r[FR_LAST].d;
    push_data.nneg = st_r[FR_LAST].nneg;
    push_data.nm   = st_r[FR_LAST].nm;
  end

endmodule

// ===== rtl/vr_queue.sv =====
// Short queue between the front and back parts of the refraction block.
// Depends on vr_pkg (qent_t, Q_DEPTH, Q_AW).
module vr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vr_pkg::qent_t  push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output vr_pkg::qent_t  head
);

  vr_pkg::qent_t         mem_r [0:vr_pkg::Q_DEPTH-1];
  logic [vr_pkg::Q_AW-1:0] wp_r;
  logic [vr_pkg::Q_AW-1:0] rp_r;
  logic [vr_pkg::Q_AW:0]   cnt_r;
  logic [vr_pkg::Q_AW:0]   cnt_nxt;

  assign full  = (cnt_r == (vr_pkg::Q_AW+1)'(vr_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/vr_back.sv =====
// Back part: final products a*normal + b*dir (or the mirror), sum and saturate.
// Depends on vr_pkg (qent_t). Drains vr_queue and drives the result channel.
module vr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  vr_pkg::qent_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_x,
  output logic [31:0]    out_y,
  output logic [31:0]    out_z,
  output logic           out_total_reflect
);

  typedef struct packed {
    logic             tir;
    logic             aneg;
    logic [2:0]       nneg;
    logic [2:0]       dneg;
    logic [2:0][31:0] d;
    logic [2:0][63:0] pl;
    logic [2:0][39:0] ph;
    logic [2:0][63:0] dp;
    logic [2:0][71:0] p1;
    logic [2:0][43:0] t1;
    logic [2:0][43:0] t2;
    logic [2:0][31:0] o;
  } bk_t;

  bk_t        b1_r, b2_r, b3_r, b4_r;
  bk_t        b1_nxt, b2_nxt, b3_nxt, b4_nxt;
  logic [3:0] bv_r;
  logic       en;

  assign en  = !(bv_r[3] && !out_ready);
  assign pop = !q_empty && en;

  always_comb begin
    logic [39:0] x;
    logic [31:0] dm;
    b1_nxt      = '0;
    b1_nxt.tir  = head.tir;
    b1_nxt.aneg = head.aneg;
    b1_nxt.nneg = head.nneg;
    b1_nxt.d    = head.d;
    x = head.tir ? {6'd0, head.c} : head.amag;
    for (int k = 0; k < 3; k++) begin
      dm = head.d[k][31] ? (~head.d[k] + 32'd1) : head.d[k];
      b1_nxt.dneg[k] = head.d[k][31];
      b1_nxt.pl[k]   = x[31:0] * head.nm[k];
      b1_nxt.ph[k]   = x[39:32] * head.nm[k];
      b1_nxt.dp[k]   = head.b * dm;
    end
  end

  always_comb begin
    b2_nxt = b1_r;
    for (int k = 0; k < 3; k++) begin
      b2_nxt.p1[k] = {8'd0, b1_r.pl[k]} + {b1_r.ph[k], 32'd0};
    end
  end

  always_comb begin
    logic [42:0] mg;
    logic        ng;
    b3_nxt = b2_r;
    for (int k = 0; k < 3; k++) begin
      // mirror uses 2*c, so drop one bit less
      mg = b2_r.tir ? b2_r.p1[k][71:29] : {1'b0, b2_r.p1[k][71:30]};
      ng = b2_r.tir ? b2_r.nneg[k] : (b2_r.aneg ^ b2_r.nneg[k]);
      b3_nxt.t1[k] = ng ? (~{1'b0, mg} + 44'd1) : {1'b0, mg};
      if (b2_r.tir) begin
        b3_nxt.t2[k] = {{12{b2_r.d[k][31]}}, b2_r.d[k]};
      end else if (b2_r.dneg[k]) begin
        b3_nxt.t2[k] = ~{8'd0, b2_r.dp[k][63:28]} + 44'd1;
      end else begin
        b3_nxt.t2[k] = {8'd0, b2_r.dp[k][63:28]};
      end
    end
  end

  always_comb begin
    logic signed [44:0] sm;
    b4_nxt = b3_r;
    for (int k = 0; k < 3; k++) begin
      sm = $signed({b3_r.t1[k][43], b3_r.t1[k]}) + $signed({b3_r.t2[k][43], b3_r.t2[k]});
      if (sm > 45'sh0_7FFF_FFFF) begin
        b4_nxt.o[k] = 32'h7FFF_FFFF;
      end else if (sm < -45'sh0_8000_0000) begin
        b4_nxt.o[k] = 32'h8000_0000;
      end else begin
        b4_nxt.o[k] = sm[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
      b3_r <= b3_nxt;
      b4_r <= b4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[2:0], pop};
    end
  end

  assign out_valid         = bv_r[3];
  assign out_x             = b4_r.o[0];
  assign out_y             = b4_r.o[1];
  assign out_z             = b4_r.o[2];
  assign out_total_reflect = b4_r.tir;

endmodule

// ===== rtl/vr_checker.sv =====
// Port-level checks for vector_refraction, bound to the top level.
// Depends only on the top level's ports.
module vr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        out_total_reflect
);

  logic [6:0] inflight_r;

  // track words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 7'(in_valid && in_ready) - 7'(out_valid && out_ready);
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input word dropped before accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_total_reflect))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 7'd0)
    else $error("result word without an accepted input word");

endmodule

bind vector_refraction vr_checker u_vr_checker (.*);
